### rtl/core/spline_scatter_resampler_macros.svh
// ----------------------------------------------------------------------------
// spline scatter resampler assertion macros
// shared concurrent assertion helpers, clocked on clk_i and quiet in reset
// ----------------------------------------------------------------------------
`ifndef SPLINE_SCATTER_RESAMPLER_MACROS_SVH
`define SPLINE_SCATTER_RESAMPLER_MACROS_SVH

// property must hold at every clock edge out of reset
`define SSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen
`define SSR_ASSERT_NEVER(lbl, cond, msg) `SSR_ASSERT(lbl, !(cond), msg)

`endif

### rtl/core/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// types and constants shared by the spline scatter resampler modules
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

  localparam int unsigned IN_SIZE_DEF  = 256;
  localparam int unsigned OUT_BINS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned BIN_W  = 6;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned PROD_W = 33;
  localparam int unsigned SHIFT  = 15;

  localparam logic [CFG_W-1:0] BINS_RESET = 7'd64;

  typedef enum logic [0:0] {
    CFG_BINS_IN_USE = 1'b0,
    CFG_WRAP_MODE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO_RD,
    ST_LO_WR,
    ST_HI_RD,
    ST_HI_WR,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [WGT_W-1:0] wlo;
    logic [WGT_W-1:0] whi;
  } map_t;

  typedef struct packed {
    logic             lo_en;
    logic             hi_en;
    logic [BIN_W-1:0] b0;
    logic [BIN_W-1:0] b1;
    logic [WGT_W-1:0] wlo;
    logic [WGT_W-1:0] whi;
    logic [SMP_W-1:0] sample;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/core/ssr_queue.sv
// ----------------------------------------------------------------------------
// ssr_queue
// short command queue between the front and back units
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ssr_pkg::cmd_t   wdata_i,
  input  logic            pop_i,
  output ssr_pkg::cmd_t   rdata_o,
  output ssr_pkg::q_stat_t stat_o
);
  import ssr_pkg::*;

  `include "spline_scatter_resampler_macros.svh"

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

  `SSR_ASSERT_NEVER(a_no_push_full, push_i && !pop_i && (count_q == QCNT_W'(QUEUE_DEPTH)), "push into full queue")
  `SSR_ASSERT_NEVER(a_no_pop_empty, pop_i && (count_q == '0), "pop from empty queue")

endmodule

`default_nettype wire

### rtl/core/ssr_front.sv
// ----------------------------------------------------------------------------
// ssr_front
// accepts transactions, owns the position map and classifies samples
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_front #(
  parameter int unsigned IN_SIZE  = ssr_pkg::IN_SIZE_DEF,
  parameter int unsigned OUT_BINS = ssr_pkg::OUT_BINS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           kind_i,
  input  logic [ssr_pkg::POS_W-1:0]      position_i,
  input  logic [ssr_pkg::BIN_W-1:0]      target_bin_i,
  input  logic [ssr_pkg::WGT_W-1:0]      weight_low_i,
  input  logic [ssr_pkg::WGT_W-1:0]      weight_high_i,
  input  logic signed [ssr_pkg::SMP_W-1:0] sample_i,
  input  logic                           last_i,
  input  logic [$clog2(OUT_BINS+1)-1:0]  n_bins_i,
  input  logic                           wrap_i,
  input  ssr_pkg::q_stat_t               q_stat_i,
  output logic                           push_o,
  output ssr_pkg::cmd_t                  cmd_o
);
  import ssr_pkg::*;

  localparam int unsigned AW = $clog2(IN_SIZE);

  map_t              map_q [IN_SIZE];
  map_t              map_rd_q;
  logic              s1_v_q;
  logic              s1_ok_q;
  logic [SMP_W-1:0]  s1_sample_q;
  logic              s1_last_q;

  logic              accept;
  logic              is_sample;
  logic [31:0]       pos_ext;
  logic              pos_ok;
  logic [AW-1:0]     addr;
  logic [BIN_W:0]    b0_ext;
  logic [BIN_W:0]    b1_ext;
  logic [BIN_W:0]    n_ext;
  logic              lo_en;
  logic              hi_past;

  assign busy_o    = (32'(q_stat_i.count) + 32'(s1_v_q)) >= QUEUE_DEPTH;
  assign accept    = start_i && !busy_o;
  assign is_sample = (kind_e'(kind_i) == KIND_SAMPLE);
  assign pos_ext   = 32'(position_i);
  assign pos_ok    = pos_ext < IN_SIZE;
  assign addr      = pos_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept && !is_sample && pos_ok) begin
      map_q[addr] <= '{bin: target_bin_i, wlo: weight_low_i, whi: weight_high_i};
    end
    map_rd_q <= map_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept && is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ok_q     <= pos_ok;
      s1_sample_q <= sample_i;
      s1_last_q   <= last_i;
    end
  end

  // classify against the bins in use
  assign n_ext   = (BIN_W+1)'(n_bins_i);
  assign b0_ext  = {1'b0, map_rd_q.bin};
  assign b1_ext  = b0_ext + 1'b1;
  assign lo_en   = s1_ok_q && (b0_ext < n_ext);
  assign hi_past = (b1_ext >= n_ext);

  always_comb begin
    cmd_o.lo_en  = lo_en;
    cmd_o.hi_en  = lo_en && (!hi_past || wrap_i);
    cmd_o.b0     = map_rd_q.bin;
    cmd_o.b1     = hi_past ? '0 : b1_ext[BIN_W-1:0];
    cmd_o.wlo    = map_rd_q.wlo;
    cmd_o.whi    = map_rd_q.whi;
    cmd_o.sample = s1_sample_q;
    cmd_o.last   = s1_last_q;
  end

  assign push_o = s1_v_q && (lo_en || s1_last_q);

endmodule

`default_nettype wire

### rtl/core/ssr_back.sv
// ----------------------------------------------------------------------------
// ssr_back
// scatter accumulation into the bin sum memory and bin readout
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_back #(
  parameter int unsigned OUT_BINS = ssr_pkg::OUT_BINS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ssr_pkg::q_stat_t                q_stat_i,
  input  ssr_pkg::cmd_t                   q_data_i,
  output logic                            pop_o,
  input  logic [$clog2(OUT_BINS+1)-1:0]   n_bins_i,
  output logic                            result_valid_o,
  output logic [ssr_pkg::BIN_W-1:0]       bin_o,
  output logic signed [ssr_pkg::VAL_W-1:0] value_o,
  output logic                            end_of_vector_o,
  output logic                            saturated_o
);
  import ssr_pkg::*;

  `include "spline_scatter_resampler_macros.svh"

  localparam int unsigned BW = $clog2(OUT_BINS);
  localparam int unsigned NW = $clog2(OUT_BINS + 1);

  back_state_e             state_q, state_d;
  cmd_t                    cmd_q;
  logic [BW-1:0]           k_q, k_d;
  logic [OUT_BINS-1:0]     vld_q;

  logic signed [ACC_W-1:0] sums_q [OUT_BINS];
  logic signed [ACC_W-1:0] rd_q;
  logic                    rd_vld_q;
  logic signed [PROD_W-1:0] prod_q;

  logic                    e1_v_q;
  logic [BW-1:0]           e1_bin_q;
  logic                    e1_eov_q;

  logic                    res_v_q;
  logic [BIN_W-1:0]        res_bin_q;
  logic signed [VAL_W-1:0] res_val_q;
  logic                    res_eov_q;

  logic [BW-1:0]           rd_addr;
  logic [BW-1:0]           wr_addr;
  logic                    we;
  logic                    clr;
  logic                    k_last;
  logic [WGT_W-1:0]        w_sel;
  logic signed [16:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [33:0]      mul_full;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;

  assign k_last = (NW'(k_q) == (n_bins_i - NW'(1)));

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    clr     = 1'b0;
    rd_addr = cmd_q.b0[BW-1:0];
    wr_addr = cmd_q.b0[BW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (q_data_i.lo_en) begin
            state_d = ST_LO_RD;
          end else if (q_data_i.last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_LO_RD: begin
        state_d = ST_LO_WR;
      end
      ST_LO_WR: begin
        we = 1'b1;
        if (cmd_q.hi_en) begin
          state_d = ST_HI_RD;
        end else if (cmd_q.last) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HI_RD: begin
        rd_addr = cmd_q.b1[BW-1:0];
        state_d = ST_HI_WR;
      end
      ST_HI_WR: begin
        we      = 1'b1;
        wr_addr = cmd_q.b1[BW-1:0];
        state_d = cmd_q.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        rd_addr = k_q;
        if (k_last) begin
          clr     = 1'b1;
          k_d     = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      vld_q   <= '0;
      e1_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (clr) begin
        vld_q <= '0;
      end else if (we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      e1_v_q  <= (state_q == ST_EMIT);
      res_v_q <= e1_v_q;
    end
  end

  // sample times weight, one product per read phase
  assign w_sel    = (state_q == ST_HI_RD) ? cmd_q.whi : cmd_q.wlo;
  assign mul_a    = 17'($signed(cmd_q.sample));
  assign mul_b    = $signed({1'b0, w_sel});
  assign mul_full = mul_a * mul_b;

  // saturating add into the 40-bit sum
  assign acc_sum = (rd_vld_q ? {rd_q[ACC_W-1], rd_q} : '0)
                 + {{(ACC_W + 1 - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_sat = acc_sum[ACC_W-1:0];
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_data_i;
    end
    prod_q <= mul_full[PROD_W-1:0];
    if (we) begin
      sums_q[wr_addr] <= acc_sat;
    end
    rd_q     <= sums_q[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
    e1_bin_q <= k_q;
    e1_eov_q <= k_last;
    // floor shift keeps the upper 25 bits, sign extended to the value width
    res_val_q <= rd_vld_q ? {{(VAL_W + SHIFT - ACC_W){rd_q[ACC_W-1]}}, rd_q[ACC_W-1:SHIFT]}
                          : '0;
    res_bin_q <= BIN_W'(e1_bin_q);
    res_eov_q <= e1_v_q && e1_eov_q;
  end

  assign result_valid_o  = res_v_q;
  assign bin_o           = res_bin_q;
  assign value_o         = res_val_q;
  assign end_of_vector_o = res_v_q && res_eov_q;
  // a 40-bit sum shifted by 15 always fits in 32 bits
  assign saturated_o     = 1'b0;

  `SSR_ASSERT(a_gap_after_vector, end_of_vector_o |=> !result_valid_o, "result right after end of vector")
  `SSR_ASSERT(a_bins_ascend, (result_valid_o && !end_of_vector_o) |=> (result_valid_o && (bin_o == $past(bin_o) + 6'd1)), "bins not in ascending order")

endmodule

`default_nettype wire

### rtl/core/spline_scatter_resampler.sv
// ----------------------------------------------------------------------------
// spline_scatter_resampler
// one-dimensional forward spline resampler with scatter accumulation
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken when start_i is high and busy_o is low. a load
//   (kind 0) writes the position map entry; a sample (kind 1) adds
//   sample*weight_low into its lower bin and sample*weight_high into the
//   next bin, wrapping in circular mode or dropped past the end otherwise.
//   a sample with last_i set then reports every bin in use, one per cycle,
//   on result_valid_o with bin_o, value_o, end_of_vector_o, saturated_o,
//   and clears the sums. the receiver cannot stall, results are never held.
// timing:
//   the front takes one transaction per cycle while there is room; busy_o is
//   high while the 4-entry queue and the map read stage hold 4 samples.
//   the back unit pops a sample in idle, then spends a read and a write
//   state per bin it touches (ST_LO_RD, ST_LO_WR, ST_HI_RD, ST_HI_WR), and
//   pops the next sample only once it is back in idle. a last sample moves
//   to ST_EMIT after its last bin write, or straight from idle if it adds
//   nothing, and reads out the bins in use with results on consecutive
//   cycles; each sum passes the rd_q and result registers to the ports.
// reset:
//   sums read as zero, 64 bins and linear mode selected, map is undefined.
//   configuration is written through cfg_we_i, cfg_index_i and cfg_data_i.
// ----------------------------------------------------------------------------
`default_nettype none

module spline_scatter_resampler #(
  parameter int unsigned IN_SIZE  = ssr_pkg::IN_SIZE_DEF,
  parameter int unsigned OUT_BINS = ssr_pkg::OUT_BINS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [ssr_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             kind_i,
  input  logic [ssr_pkg::POS_W-1:0]        position_i,
  input  logic [ssr_pkg::BIN_W-1:0]        target_bin_i,
  input  logic [ssr_pkg::WGT_W-1:0]        weight_low_i,
  input  logic [ssr_pkg::WGT_W-1:0]        weight_high_i,
  input  logic signed [ssr_pkg::SMP_W-1:0] sample_i,
  input  logic                             last_i,
  output logic                             result_valid_o,
  output logic [ssr_pkg::BIN_W-1:0]        bin_o,
  output logic signed [ssr_pkg::VAL_W-1:0] value_o,
  output logic                             end_of_vector_o,
  output logic                             saturated_o
);
  import ssr_pkg::*;

  localparam int unsigned NW = $clog2(OUT_BINS + 1);

  logic [CFG_W-1:0] bins_q;
  logic             wrap_q;
  logic [NW-1:0]    n_bins;
  q_stat_t          q_stat;
  cmd_t             push_cmd;
  cmd_t             pop_cmd;
  logic             push;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_RESET;
      wrap_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BINS_IN_USE: bins_q <= cfg_data_i;
        CFG_WRAP_MODE:   wrap_q <= cfg_data_i[0];
        default:         bins_q <= bins_q;
      endcase
    end
  end

  // clamp bins in use to the supported range
  always_comb begin
    if (32'(bins_q) < 32'd2) begin
      n_bins = NW'(2);
    end else if (32'(bins_q) > OUT_BINS) begin
      n_bins = NW'(OUT_BINS);
    end else begin
      n_bins = NW'(bins_q);
    end
  end

  ssr_front #(
    .IN_SIZE  (IN_SIZE),
    .OUT_BINS (OUT_BINS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .target_bin_i  (target_bin_i),
    .weight_low_i  (weight_low_i),
    .weight_high_i (weight_high_i),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .n_bins_i      (n_bins),
    .wrap_i        (wrap_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  ssr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .stat_o  (q_stat)
  );

  ssr_back #(
    .OUT_BINS (OUT_BINS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .q_data_i        (pop_cmd),
    .pop_o           (pop),
    .n_bins_i        (n_bins),
    .result_valid_o  (result_valid_o),
    .bin_o           (bin_o),
    .value_o         (value_o),
    .end_of_vector_o (end_of_vector_o),
    .saturated_o     (saturated_o)
  );

endmodule

`default_nettype wire
